>>> sv/uvs_pkg.sv
`default_nettype none
package uvs_pkg;

  // Band limits and fixed-point constants.
  localparam int MAX_BANDS    = 128;
  localparam int MIN_BANDS    = 3;
  localparam int CORDIC_STEPS = 16;
  localparam int BAND_W       = 8;
  localparam int IDX_W        = 8;
  localparam int RAD_W        = 16;
  localparam int ONE_Q14      = 16384;
  localparam int RADIUS_MAX   = 40960;
  localparam int GAIN_Q30     = 652032874;

  // Divider: one quotient bit per stage over the whole numerator.
  localparam int DIV_W   = 40;
  localparam int REM_W   = BAND_W - 1;

  // CORDIC datapath width (Q2.30 with headroom) and pipeline depth.
  localparam int CW          = 34;
  localparam int CORDIC_LAT  = CORDIC_STEPS + 2;

  // Queue between the front and the back.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_LAT_BANDS = 2'd0,
    REG_LON_BANDS = 2'd1,
    REG_RADIUS    = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [BAND_W-1:0] lat_bands;
    logic [BAND_W-1:0] lon_bands;
    logic [RAD_W-1:0]  radius;
  } cfg_t;

  // One classified lattice point with the settings in force.
  typedef struct packed {
    logic [IDX_W-1:0]  lat;
    logic [IDX_W-1:0]  lon;
    logic [BAND_W-1:0] lb;
    logic [BAND_W-1:0] ob;
    logic [RAD_W-1:0]  radius;
    logic              clamped;
  } item_t;

  // Sideband that travels beside the divider lanes.
  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic             clamped;
  } dside_t;

  // Sideband that travels beside the CORDIC lanes.
  typedef struct packed {
    logic [RAD_W-1:0] radius;
    logic             clamped;
    logic [14:0]      tex_u;
    logic [14:0]      tex_v;
  } cside_t;

endpackage
`default_nettype wire

>>> sv/uvs_front.sv
`default_nettype none
module uvs_front (
  input  var uvs_pkg::cfg_t              cfg,
  input  wire logic [uvs_pkg::IDX_W-1:0] lat_index,
  input  wire logic [uvs_pkg::IDX_W-1:0] lon_index,
  output uvs_pkg::item_t                 item
);

  logic [uvs_pkg::BAND_W-1:0] lb;
  logic [uvs_pkg::BAND_W-1:0] ob;
  logic [uvs_pkg::RAD_W-1:0]  rad;
  logic lat_over;
  logic lon_over;

  // Band counts in use and the radius limit.
  always_comb begin
    if (cfg.lat_bands < uvs_pkg::BAND_W'(uvs_pkg::MIN_BANDS)) begin
      lb = uvs_pkg::BAND_W'(uvs_pkg::MIN_BANDS);
    end else if (cfg.lat_bands > uvs_pkg::BAND_W'(uvs_pkg::MAX_BANDS)) begin
      lb = uvs_pkg::BAND_W'(uvs_pkg::MAX_BANDS);
    end else begin
      lb = cfg.lat_bands;
    end
    if (cfg.lon_bands < uvs_pkg::BAND_W'(uvs_pkg::MIN_BANDS)) begin
      ob = uvs_pkg::BAND_W'(uvs_pkg::MIN_BANDS);
    end else if (cfg.lon_bands > uvs_pkg::BAND_W'(uvs_pkg::MAX_BANDS)) begin
      ob = uvs_pkg::BAND_W'(uvs_pkg::MAX_BANDS);
    end else begin
      ob = cfg.lon_bands;
    end
    if (cfg.radius > uvs_pkg::RAD_W'(uvs_pkg::RADIUS_MAX)) begin
      rad = uvs_pkg::RAD_W'(uvs_pkg::RADIUS_MAX);
    end else begin
      rad = cfg.radius;
    end
  end

  // Clamp indices that run past their band count.
  always_comb begin
    lat_over     = lat_index > lb;
    lon_over     = lon_index > ob;
    item.lat     = lat_over ? lb : lat_index;
    item.lon     = lon_over ? ob : lon_index;
    item.lb      = lb;
    item.ob      = ob;
    item.radius  = rad;
    item.clamped = lat_over | lon_over;
  end

endmodule
`default_nettype wire

>>> sv/uvs_fifo.sv
`default_nettype none
module uvs_fifo (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  var uvs_pkg::item_t wdata,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output uvs_pkg::item_t rdata
);

  uvs_pkg::item_t mem [uvs_pkg::QDEPTH];
  logic [uvs_pkg::QPTR_W-1:0] wptr;
  logic [uvs_pkg::QPTR_W-1:0] rptr;
  logic [uvs_pkg::QPTR_W:0]   count;

  assign full  = count == (uvs_pkg::QPTR_W+1)'(uvs_pkg::QDEPTH);
  assign empty = count == '0;
  assign rdata = mem[rptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      count <= count + (uvs_pkg::QPTR_W+1)'(push) - (uvs_pkg::QPTR_W+1)'(pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule
`default_nettype wire

>>> sv/uvs_div.sv
`default_nettype none
module uvs_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [uvs_pkg::DIV_W-1:0]   num,
  input  wire logic [uvs_pkg::BAND_W-1:0]  den,
  output logic      [uvs_pkg::DIV_W-1:0]   quo
);

  logic [uvs_pkg::REM_W-1:0]  rem_q [uvs_pkg::DIV_W];
  logic [uvs_pkg::DIV_W-1:0]  nq_q  [uvs_pkg::DIV_W];
  logic [uvs_pkg::BAND_W-1:0] den_q [uvs_pkg::DIV_W];
  logic [uvs_pkg::REM_W-1:0]  rem_n [uvs_pkg::DIV_W];
  logic [uvs_pkg::DIV_W-1:0]  nq_n  [uvs_pkg::DIV_W];
  logic [uvs_pkg::BAND_W-1:0] den_n [uvs_pkg::DIV_W];

  // One restoring step per stage: shift in a numerator bit, subtract if it fits.
  always_comb begin
    logic [uvs_pkg::REM_W-1:0]  r;
    logic [uvs_pkg::DIV_W-1:0]  nq;
    logic [uvs_pkg::BAND_W-1:0] d;
    logic [uvs_pkg::BAND_W-1:0] t;
    logic ge;
    for (int k = 0; k < uvs_pkg::DIV_W; k++) begin
      if (k == 0) begin
        r  = '0;
        nq = num;
        d  = den;
      end else begin
        r  = rem_q[k-1];
        nq = nq_q[k-1];
        d  = den_q[k-1];
      end
      t        = {r, nq[uvs_pkg::DIV_W-1]};
      ge       = t >= d;
      rem_n[k] = ge ? uvs_pkg::REM_W'(t - d) : uvs_pkg::REM_W'(t);
      nq_n[k]  = {nq[uvs_pkg::DIV_W-2:0], ge};
      den_n[k] = d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_q <= rem_n;
      nq_q  <= nq_n;
      den_q <= den_n;
    end
  end

  assign quo = nq_q[uvs_pkg::DIV_W-1];

endmodule
`default_nettype wire

>>> sv/uvs_cordic.sv
`default_nettype none
module uvs_cordic (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [31:0] phase,
  output logic signed [15:0] cos_o,
  output logic signed [15:0] sin_o
);

  localparam logic signed [uvs_pkg::CW-1:0] QUARTER = uvs_pkg::CW'(64'sd1 <<< 30);
  localparam logic signed [uvs_pkg::CW-1:0] HALF    = uvs_pkg::CW'(64'sd1 <<< 31);
  localparam logic signed [uvs_pkg::CW-1:0] RND     = uvs_pkg::CW'(32768);
  localparam logic signed [17:0] LIM = 18'sd16384;

  logic signed [uvs_pkg::CW-1:0] x_q [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] y_q [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] z_q [uvs_pkg::CORDIC_STEPS+1];
  logic                          neg_q [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] x_n [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] y_n [uvs_pkg::CORDIC_STEPS+1];
  logic signed [uvs_pkg::CW-1:0] z_n [uvs_pkg::CORDIC_STEPS+1];
  logic                          neg_n [uvs_pkg::CORDIC_STEPS+1];
  logic signed [15:0] cos_n;
  logic signed [15:0] sin_n;

  function automatic logic [31:0] ATAN_SEL(input int i);
    return uvs_pkg::ATAN_TURNS[i];
  endfunction

  // Quadrant folding, then the micro-rotations, one per stage.
  always_comb begin
    logic signed [uvs_pkg::CW-1:0] z0;
    logic signed [uvs_pkg::CW-1:0] a;
    z0 = uvs_pkg::CW'($signed(phase));
    x_n[0] = uvs_pkg::CW'(uvs_pkg::GAIN_Q30);
    y_n[0] = '0;
    if (z0 > QUARTER) begin
      z_n[0]   = z0 - HALF;
      neg_n[0] = 1'b1;
    end else if (z0 < -QUARTER) begin
      z_n[0]   = z0 + HALF;
      neg_n[0] = 1'b1;
    end else begin
      z_n[0]   = z0;
      neg_n[0] = 1'b0;
    end
    for (int i = 0; i < uvs_pkg::CORDIC_STEPS; i++) begin
      a = uvs_pkg::CW'(ATAN_SEL(i));
      if (z_q[i] >= 0) begin
        x_n[i+1] = x_q[i] - (y_q[i] >>> i);
        y_n[i+1] = y_q[i] + (x_q[i] >>> i);
        z_n[i+1] = z_q[i] - a;
      end else begin
        x_n[i+1] = x_q[i] + (y_q[i] >>> i);
        y_n[i+1] = y_q[i] - (x_q[i] >>> i);
        z_n[i+1] = z_q[i] + a;
      end
      neg_n[i+1] = neg_q[i];
    end
  end

  // Round to Q1.14, saturate, and undo the quadrant fold.
  always_comb begin
    logic signed [uvs_pkg::CW-1:0] xs;
    logic signed [uvs_pkg::CW-1:0] ys;
    logic signed [17:0] xr;
    logic signed [17:0] yr;
    xs = (x_q[uvs_pkg::CORDIC_STEPS] + RND) >>> 16;
    ys = (y_q[uvs_pkg::CORDIC_STEPS] + RND) >>> 16;
    xr = 18'(xs);
    yr = 18'(ys);
    if (xr > LIM) xr = LIM;
    else if (xr < -LIM) xr = -LIM;
    if (yr > LIM) yr = LIM;
    else if (yr < -LIM) yr = -LIM;
    if (neg_q[uvs_pkg::CORDIC_STEPS]) begin
      xr = -xr;
      yr = -yr;
    end
    cos_n = 16'(xr);
    sin_n = 16'(yr);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_q   <= x_n;
      y_q   <= y_n;
      z_q   <= z_n;
      neg_q <= neg_n;
      cos_o <= cos_n;
      sin_o <= sin_n;
    end
  end

endmodule
`default_nettype wire

>>> sv/uvs_back.sv
`default_nettype none
module uvs_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  var uvs_pkg::item_t  q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic signed [16:0]  pos_x,
  output logic signed [16:0]  pos_y,
  output logic signed [16:0]  pos_z,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic [14:0]         tex_u,
  output logic [14:0]         tex_v,
  output logic                index_clamped
);

  localparam int DL = uvs_pkg::DIV_W;
  localparam int CL = uvs_pkg::CORDIC_LAT;
  localparam logic [uvs_pkg::DIV_W-1:0] ONE_Q = uvs_pkg::DIV_W'(uvs_pkg::ONE_Q14);

  logic adv;
  logic [uvs_pkg::DIV_W-1:0] q_theta, q_phi, q_u, q_v;
  logic signed [15:0] ct, st, cp, sp;

  logic             dv [DL];
  uvs_pkg::dside_t  dsb [DL];
  logic             cv [CL];
  uvs_pkg::cside_t  csb [CL];
  uvs_pkg::cside_t  csb_in;

  logic               uv_valid;
  uvs_pkg::cside_t    usb;
  logic signed [15:0] ux, uy, uz;

  // The whole pipe moves when the output register is free or being taken.
  assign adv   = !out_valid || out_ready;
  assign q_pop = adv && !q_empty;

  // Four divider lanes: both phases and both texture coordinates.
  uvs_div u_div_theta (
    .clk(clk), .en(adv),
    .num((uvs_pkg::DIV_W'(q_item.lat) << 31) + uvs_pkg::DIV_W'(q_item.lb >> 1)),
    .den(q_item.lb), .quo(q_theta)
  );
  uvs_div u_div_phi (
    .clk(clk), .en(adv),
    .num((uvs_pkg::DIV_W'(q_item.lon) << 32) + uvs_pkg::DIV_W'(q_item.ob >> 1)),
    .den(q_item.ob), .quo(q_phi)
  );
  uvs_div u_div_u (
    .clk(clk), .en(adv),
    .num((uvs_pkg::DIV_W'(q_item.lon) << 14) + uvs_pkg::DIV_W'(q_item.ob >> 1)),
    .den(q_item.ob), .quo(q_u)
  );
  uvs_div u_div_v (
    .clk(clk), .en(adv),
    .num((uvs_pkg::DIV_W'(q_item.lat) << 14) + uvs_pkg::DIV_W'(q_item.lb >> 1)),
    .den(q_item.lb), .quo(q_v)
  );

  // Sine and cosine of both angles.
  uvs_cordic u_cordic_theta (
    .clk(clk), .en(adv), .phase(q_theta[31:0]), .cos_o(ct), .sin_o(st)
  );
  uvs_cordic u_cordic_phi (
    .clk(clk), .en(adv), .phase(q_phi[31:0]), .cos_o(cp), .sin_o(sp)
  );

  // Texture coordinates once the dividers finish.
  always_comb begin
    csb_in.radius  = dsb[DL-1].radius;
    csb_in.clamped = dsb[DL-1].clamped;
    csb_in.tex_u   = (q_u > ONE_Q) ? 15'(uvs_pkg::ONE_Q14) : q_u[14:0];
    csb_in.tex_v   = (q_v > ONE_Q) ? 15'd0 : 15'(ONE_Q - q_v);
  end

  // Valid bits are the only control state of the pipe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DL; k++) dv[k] <= 1'b0;
      for (int k = 0; k < CL; k++) cv[k] <= 1'b0;
      uv_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      dv[0] <= q_pop;
      for (int k = 1; k < DL; k++) dv[k] <= dv[k-1];
      cv[0] <= dv[DL-1];
      for (int k = 1; k < CL; k++) cv[k] <= cv[k-1];
      uv_valid  <= cv[CL-1];
      out_valid <= uv_valid;
    end
  end

  // Sideband lines that keep pace with the lanes.
  always_ff @(posedge clk) begin
    if (adv) begin
      dsb[0].radius  <= q_item.radius;
      dsb[0].clamped <= q_item.clamped;
      for (int k = 1; k < DL; k++) dsb[k] <= dsb[k-1];
      csb[0] <= csb_in;
      for (int k = 1; k < CL; k++) csb[k] <= csb[k-1];
    end
  end

  // Unit vector: combine azimuth with the polar sine.
  always_ff @(posedge clk) begin
    logic signed [32:0] px;
    logic signed [32:0] pz;
    logic signed [18:0] rx;
    logic signed [18:0] rz;
    if (adv) begin
      px = 33'(cp * st) + 33'sd8192;
      pz = 33'(sp * st) + 33'sd8192;
      rx = 19'(px >>> 14);
      rz = 19'(pz >>> 14);
      if (rx > 19'sd16384) rx = 19'sd16384;
      else if (rx < -19'sd16384) rx = -19'sd16384;
      if (rz > 19'sd16384) rz = 19'sd16384;
      else if (rz < -19'sd16384) rz = -19'sd16384;
      ux  <= 16'(rx);
      uz  <= 16'(rz);
      uy  <= ct;
      usb <= csb[CL-1];
    end
  end

  function automatic logic signed [16:0] scale(input logic [15:0] r,
                                               input logic signed [15:0] u);
    logic signed [33:0] p;
    logic signed [19:0] s;
    p = 34'($signed({1'b0, r}) * u) + 34'sd8192;
    s = 20'(p >>> 14);
    if (s > 20'sd40960) s = 20'sd40960;
    else if (s < -20'sd40960) s = -20'sd40960;
    return 17'(s);
  endfunction

  // Output register: position, normal and texture coordinate.
  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x         <= scale(usb.radius, ux);
      pos_y         <= scale(usb.radius, uy);
      pos_z         <= scale(usb.radius, uz);
      normal_x      <= (usb.radius == '0) ? 16'sd0 : ux;
      normal_y      <= (usb.radius == '0) ? 16'sd0 : uy;
      normal_z      <= (usb.radius == '0) ? 16'sd0 : uz;
      tex_u         <= usb.tex_u;
      tex_v         <= usb.tex_v;
      index_clamped <= usb.clamped;
    end
  end

endmodule
`default_nettype wire

>>> sv/uv_sphere_vertex_generator.sv
`default_nettype none
// UV-sphere vertex generator. Each input beat carries one lattice point (lat_index in
// s_axis_tdata[7:0], lon_index in [15:8]); each output beat carries its position (Q4.12),
// unit normal (Q1.14) and texture coordinate (Q1.14), with index_clamped on m_axis_tuser.
// One beat is accepted per clock while the output keeps flowing; each result passes through
// a 4-entry input queue, the 40-stage phase dividers, the 18-stage CORDIC pipes and two
// multiplier stages. Band counts and radius are set through the APB port (0x0, 0x4, 0x8)
// and should change only while idle.
module uv_sphere_vertex_generator (
  input  wire logic         clk,
  input  wire logic         rst,
  // APB configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // Input stream: lat_index [7:0], lon_index [15:8].
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [15:0]  s_axis_tdata,
  // Output stream: pos_x [16:0], pos_y [33:17], pos_z [50:34], normal_x [66:51],
  // normal_y [82:67], normal_z [98:83], tex_u [113:99], tex_v [128:114], zero pad.
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [135:0]      m_axis_tdata,
  // Output user: index_clamped [0].
  output logic              m_axis_tuser
);

  uvs_pkg::cfg_t  cfg;
  uvs_pkg::item_t f_item;
  uvs_pkg::item_t q_item;
  uvs_pkg::reg_idx_t widx;
  logic q_full, q_empty, q_pop;
  logic signed [16:0] pos_x, pos_y, pos_z;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic [14:0] tex_u, tex_v;

  assign pready = 1'b1;
  assign widx   = uvs_pkg::reg_idx_t'(paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lat_bands <= 8'd16;
      cfg.lon_bands <= 8'd16;
      cfg.radius    <= 16'd4096;
    end else if (psel && penable && pwrite) begin
      case (widx)
        uvs_pkg::REG_LAT_BANDS: cfg.lat_bands <= pwdata[7:0];
        uvs_pkg::REG_LON_BANDS: cfg.lon_bands <= pwdata[7:0];
        uvs_pkg::REG_RADIUS:    cfg.radius    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (widx)
      uvs_pkg::REG_LAT_BANDS: prdata = {24'd0, cfg.lat_bands};
      uvs_pkg::REG_LON_BANDS: prdata = {24'd0, cfg.lon_bands};
      uvs_pkg::REG_RADIUS:    prdata = {16'd0, cfg.radius};
      default:                prdata = '0;
    endcase
  end

  uvs_front u_front (
    .cfg(cfg), .lat_index(s_axis_tdata[7:0]), .lon_index(s_axis_tdata[15:8]),
    .item(f_item)
  );

  assign s_axis_tready = !q_full;

  uvs_fifo u_fifo (
    .clk(clk), .rst(rst),
    .push(s_axis_tvalid && !q_full), .wdata(f_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .rdata(q_item)
  );

  uvs_back u_back (
    .clk(clk), .rst(rst),
    .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
    .normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z),
    .tex_u(tex_u), .tex_v(tex_v), .index_clamped(m_axis_tuser)
  );

  assign m_axis_tdata = {7'd0, tex_v, tex_u, normal_z, normal_y, normal_x,
                         pos_z, pos_y, pos_x};

endmodule
`default_nettype wire

>>> sv/uvs_checker.sv
`default_nettype none
module uvs_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [135:0] m_axis_tdata
);

  // A stalled output beat stays offered.
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // A stalled output beat keeps its payload.
  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output payload changed while stalled");

  // Texture u never passes one.
  a_tex_u: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[113:99] <= 15'd16384)
    else $error("tex_u out of range");

  // No result leaves right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind uv_sphere_vertex_generator uvs_checker u_uvs_checker (
  .clk(clk), .rst(rst), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
